### rtl/core/soft_clip_sample_mixer_core_defines.svh
// Assertion macros for the soft-clip sample mixer
`ifndef SOFT_CLIP_SAMPLE_MIXER_CORE_DEFINES_SVH
`define SOFT_CLIP_SAMPLE_MIXER_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SCSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SCSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/scsm_pkg.sv
// Shared constants for the soft-clip sample mixer pipeline
package scsm_pkg;

  localparam int SampleW = 16;
  localparam int MagW    = 17;   // |a + b| up to 65536
  localparam int SqW     = 33;   // mag^2 up to 2^32
  localparam int KtW     = 35;   // 27*2^30 + mag^2
  localparam int QW      = 36;   // 27*2^30 + 9*mag^2
  localparam int PW      = 51;   // mag * (27*2^30 + mag^2)
  localparam int QuoW    = 15;   // result magnitude stays below 2^15

  localparam logic [QW-1:0] K27 = QW'(27) << 30;

  // stage map: 0 sum/abs, 1 square, 2 sums, 3 product, 4 scale,
  // 5..19 one quotient bit each, 20 output register
  localparam int StScale   = 4;
  localparam int NumStages = StScale + QuoW + 2;
  localparam int StOut     = NumStages - 1;

endpackage

### rtl/core/soft_clip_sample_mixer_core.sv
// Soft-clip sample mixer: adds two samples and applies a tanh-style clipper.
//
// Input request: in_tdata carries two signed 16-bit samples; it is taken when
// in_tvalid and in_tready are both high. Output request: out_tdata carries one
// signed 16-bit clipped sample, one per input request, in order.
// The sum s = a + b is mapped through s(27*2^30+s^2)/(27*2^30+9s^2), scaled by
// 32767/32768 and truncated toward zero; the magnitude never exceeds 32246.
// Throughput is one sample pair per cycle while out_tready is high.
// Depth is set by the exact quotient: a restoring divider unrolled into
// 15 stages, one quotient bit per stage, behind five stages of sum, square,
// product and scaling.
// Each stage carries its own valid bit; a stage loads whenever it is empty or
// the stage after it moves, so bubbles close up under backpressure and
// in_tready stays high while any stage is free, even when out_tready is low.
// A stalled output holds its data. Synchronous active-low reset empties the
// pipeline; no data is lost or repeated across stalls.
module soft_clip_sample_mixer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] sample_a, [31:16] sample_b
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] mixed_sample
);
  import scsm_pkg::*;

  logic [NumStages-1:0] vld_r;
  logic [NumStages-1:0] vld_nxt;
  logic [NumStages-1:0] en;

  // stage 0
  logic             neg0_r;
  logic [MagW-1:0]  mag0_r;
  logic [MagW-1:0]  sum0;
  // stage 1
  logic             neg1_r;
  logic [MagW-1:0]  mag1_r;
  logic [SqW-1:0]   sq1_r;
  logic [2*MagW-1:0] sq_full;
  // stage 2
  logic             neg2_r;
  logic [MagW-1:0]  mag2_r;
  logic [KtW-1:0]   kt2_r;
  logic [QW-1:0]    q2_r;
  // stage 3
  logic             neg3_r;
  logic [PW-1:0]    p3_r;
  logic [QW-1:0]    q3_r;
  logic [MagW+KtW-1:0] p_full;
  // stage 4 onward: scaled dividend then one quotient bit per stage
  logic             ngd_r  [QuoW+1];
  logic [PW-1:0]    rem_r  [QuoW+1];
  logic [QW-1:0]    qd_r   [QuoW+1];
  logic [QuoW-1:0]  quo_r  [QuoW+1];
  logic [PW+QuoW-1:0] scaled;
  // output stage
  logic [SampleW-1:0] out_data_r;

  // ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    en[StOut] = !vld_r[StOut] || out_tready;
    for (int k = StOut - 1; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 0) ? in_tvalid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[StOut];
  assign out_tdata  = out_data_r;

  // sum and magnitude
  assign sum0 = {in_tdata[15], in_tdata[15:0]} + {in_tdata[31], in_tdata[31:16]};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      neg0_r <= sum0[MagW-1];
      mag0_r <= sum0[MagW-1] ? (~sum0 + MagW'(1)) : sum0;
    end
  end

  // square
  assign sq_full = {{MagW{1'b0}}, mag0_r} * {{MagW{1'b0}}, mag0_r};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg1_r <= neg0_r;
      mag1_r <= mag0_r;
      sq1_r  <= sq_full[SqW-1:0];
    end
  end

  // numerator factor and denominator
  always_ff @(posedge clk) begin
    if (en[2]) begin
      neg2_r <= neg1_r;
      mag2_r <= mag1_r;
      kt2_r  <= K27[KtW-1:0] + {{(KtW-SqW){1'b0}}, sq1_r};
      q2_r   <= K27 + {{(QW-SqW){1'b0}}, sq1_r} + {sq1_r, 3'b000};
    end
  end

  // numerator product
  assign p_full = {{KtW{1'b0}}, mag2_r} * {{MagW{1'b0}}, kt2_r};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg3_r <= neg2_r;
      p3_r   <= p_full[PW-1:0];
      q3_r   <= q2_r;
    end
  end

  // dividend = floor(32767 * p / 32768)
  assign scaled = {p3_r, {QuoW{1'b0}}} - {{QuoW{1'b0}}, p3_r};

  always_ff @(posedge clk) begin
    if (en[StScale]) begin
      ngd_r[0] <= neg3_r;
      rem_r[0] <= scaled[PW+QuoW-1:QuoW];
      qd_r[0]  <= q3_r;
      quo_r[0] <= '0;
    end
  end

  // restoring divider, MSB first
  for (genvar j = 1; j <= QuoW; j++) begin : g_div
    localparam int Sh = QuoW - j;
    logic [PW:0] trial;

    assign trial = {1'b0, rem_r[j-1]} - ({{(PW+1-QW){1'b0}}, qd_r[j-1]} << Sh);

    always_ff @(posedge clk) begin
      if (en[StScale + j]) begin
        ngd_r[j] <= ngd_r[j-1];
        qd_r[j]  <= qd_r[j-1];
        if (!trial[PW]) begin
          rem_r[j] <= trial[PW-1:0];
          quo_r[j] <= quo_r[j-1] | (QuoW'(1) << Sh);
        end else begin
          rem_r[j] <= rem_r[j-1];
          quo_r[j] <= quo_r[j-1];
        end
      end
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    if (en[StOut]) begin
      if (ngd_r[QuoW]) begin
        out_data_r <= ~{1'b0, quo_r[QuoW]} + SampleW'(1);
      end else begin
        out_data_r <= {1'b0, quo_r[QuoW]};
      end
    end
  end

endmodule

### rtl/core/scsm_checker.sv
// Port-level checks for the soft-clip sample mixer, bound to the top level
`include "soft_clip_sample_mixer_core_defines.svh"

module scsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // a stalled output request keeps its valid and its data
  `SCSM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output request dropped or changed while stalled")

  // an empty output stage means the whole pipeline can take a request
  `SCSM_ASSERT_NOW(a_ready_when_drained, !out_tvalid, in_tready, "input not ready with output stage empty")

  // a draining output lets every stage move
  `SCSM_ASSERT_NOW(a_ready_when_taken, out_tready, in_tready, "input not ready while output drains")

  // clipper output magnitude is bounded
  `SCSM_ASSERT_NOW(a_out_range, out_tvalid, ($signed(out_tdata) <= 16'sd32246) && ($signed(out_tdata) >= -16'sd32246), "output sample outside clip range")

endmodule

bind soft_clip_sample_mixer_core scsm_checker u_scsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
